FILE: hdl/lsre_pkg.sv
// Shared constants for the link-state route engine.
// Command and result kind codes, field widths, path cost limits.
// No dependencies.
package lsre_pkg;

	localparam logic [1:0] CMD_ADD_LINK = 2'd0;
	localparam logic [1:0] CMD_HELLO    = 2'd1;
	localparam logic [1:0] CMD_RECORD   = 2'd2;
	localparam logic [1:0] CMD_NOP      = 2'd3;

	localparam logic [1:0] KIND_HELLO   = 2'd0;
	localparam logic [1:0] KIND_RECORD  = 2'd1;
	localparam logic [1:0] KIND_ROUTE   = 2'd2;

	localparam int ID_W    = 4;
	localparam int LINK_W  = 8;
	localparam int LCOST_W = 16;
	localparam int PCOST_W = 19;

	localparam logic [PCOST_W-1:0] COST_MAX = 19'h7FFFF;
	localparam logic [PCOST_W:0]   COST_INF = 20'h80000;

endpackage

FILE: hdl/link_state_route_engine_top.sv
// Link-state route engine: record table in one synchronous RAM, sequencer for
// dedup, hello replies, shortest-path search, flooding and route table output.
// Depends on lsre_pkg.
//
// Usage:
//  - cfg_we/cfg_wdata set own_router_id (reset value 1); write only while idle.
//  - Input channel (in_valid/in_ready) takes one item at a time; in_ready is
//    high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) is one output register; last marks
//    the final result of an item. A stalled receiver freezes the sequencer at
//    its next emit, the held item stays unchanged.
//  - Add own link: dedup scan of the own records, then one hello.
//  - Hello: one record result per stored record, sent on the hello's link.
//  - Link record: dedup scan, then, if the record is stored, the path search.
//    Each of up to ROUTERS-1 rounds picks a node; each edge of the picked
//    node scans the RAM record by record for its other end. Floods (only
//    with a valid own id) and ROUTERS route entries follow.
//  - Reset clears counts, neighbor state and the output register; the RAM
//    holds no reset state and is read only below each row's count.
module link_state_route_engine_top #(
	parameter int ROUTERS          = 8,
	parameter int LINKS_PER_ROUTER = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [3:0]  router_num,
	input  logic [7:0]  link_num,
	input  logic [15:0] item_cost,
	input  logic [7:0]  arrival_link,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  subject_router,
	output logic [7:0]  rec_link,
	output logic [18:0] cost_value,
	output logic [7:0]  send_link,
	output logic [3:0]  next_hop,
	output logic        reachable,
	output logic        last
);
	import lsre_pkg::*;

	localparam int RW    = $clog2(ROUTERS);
	localparam int SW    = (LINKS_PER_ROUTER > 1) ? $clog2(LINKS_PER_ROUTER) : 1;
	localparam int CW    = $clog2(LINKS_PER_ROUTER + 1);
	localparam int RCW   = $clog2(ROUTERS + 1);
	localparam int AW    = RW + SW;
	localparam int DEPTH = 2 ** AW;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DUP_RD, ST_DUP_CHK, ST_APPEND, ST_HELLO_OUT,
		ST_REC_SCAN, ST_REC_OUT, ST_INIT_RD, ST_INIT_CHK, ST_SEL,
		ST_SETTLE, ST_EDGE_RD, ST_EDGE_CAP, ST_OE_RD, ST_OE_CHK,
		ST_RELAX, ST_FLOOD_RD, ST_FLOOD_CHK, ST_ROUTE
	} state_t;

	state_t state_q;

	logic [LINK_W+LCOST_W-1:0] mem [DEPTH];
	logic [LINK_W+LCOST_W-1:0] rd_data_q;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic                      mem_we;

	logic [ID_W-1:0]    own_q;
	logic [1:0]         cmd_q;
	logic [ID_W-1:0]    rn_q;
	logic [LINK_W-1:0]  link_q;
	logic [LCOST_W-1:0] cost_q;
	logic [LINK_W-1:0]  arr_q;
	logic [RW-1:0]      tr_q;
	logic [CW-1:0]      sl_q;
	logic [CW-1:0]      osl_q;
	logic [RCW-1:0]     rr_q;
	logic [RCW-1:0]     iter_q;
	logic [RW-1:0]      w_q;
	logic               wfound_q;
	logic [PCOST_W:0]   best_q;
	logic [PCOST_W-1:0] wcost_q;
	logic [ID_W-1:0]    whop_q;
	logic [LINK_W-1:0]  e_link_q;
	logic [LCOST_W-1:0] e_cost_q;
	logic [RW-1:0]      d_q;

	logic [CW-1:0]      cnt_q   [ROUTERS];
	logic               nbv_q   [ROUTERS];
	logic [LINK_W-1:0]  nbl_q   [ROUTERS];
	logic [PCOST_W-1:0] pc_q    [ROUTERS];
	logic [ID_W-1:0]    fh_q    [ROUTERS];
	logic [ROUTERS-1:0] settled_q;
	logic [ROUTERS-1:0] reach_q;

	logic               ov_q;
	logic [1:0]         o_kind_q;
	logic [ID_W-1:0]    o_subj_q;
	logic [LINK_W-1:0]  o_rlink_q;
	logic [PCOST_W-1:0] o_cost_q;
	logic [LINK_W-1:0]  o_slink_q;
	logic [ID_W-1:0]    o_hop_q;
	logic               o_reach_q;
	logic               o_last_q;

	logic               own_ok;
	logic [RW-1:0]      own_idx;
	logic               rn_in_ok;
	logic [RW-1:0]      rn_in_idx;
	logic [LINK_W-1:0]  rd_link;
	logic [LCOST_W-1:0] rd_cost;
	logic [RW-1:0]      rr_idx;
	logic               rr_end;
	logic [RW-1:0]      cnt_idx;
	logic [CW-1:0]      cnt_rd;
	logic [RW-1:0]      pc_idx;
	logic [PCOST_W-1:0] pc_rd;
	logic [ID_W-1:0]    fh_rd;
	logic               later_nz;
	logic               rec_last;
	logic               nb_hit;
	logic [PCOST_W:0]   sum_w;
	logic [PCOST_W-1:0] sum_sat;
	logic [PCOST_W:0]   key;
	logic               out_free;
	logic [CW-1:0]      sl_inc;
	logic               flood_ok;
	logic               emit;

	assign own_ok    = (own_q >= 4'd1) && (own_q <= 4'(ROUTERS));
	assign own_idx   = RW'(own_q - 4'd1);
	assign rn_in_ok  = (router_num >= 4'd1) && (router_num <= 4'(ROUTERS));
	assign rn_in_idx = RW'(router_num - 4'd1);
	assign rd_link   = rd_data_q[LINK_W+LCOST_W-1:LCOST_W];
	assign rd_cost   = rd_data_q[LCOST_W-1:0];
	assign rr_idx    = rr_q[RW-1:0];
	assign rr_end    = (rr_q == RCW'(ROUTERS));
	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign sl_inc    = sl_q + CW'(1);
	assign flood_ok  = (rd_link != arr_q) && nb_hit;

	always_comb begin
		case (state_q)
			ST_SETTLE, ST_EDGE_RD, ST_EDGE_CAP:
				cnt_idx = w_q;
			ST_REC_SCAN, ST_REC_OUT, ST_OE_RD, ST_OE_CHK, ST_SEL:
				cnt_idx = rr_idx;
			default:
				cnt_idx = tr_q;
		endcase
		case (state_q)
			ST_EDGE_RD, ST_EDGE_CAP:
				rd_addr = {w_q, sl_q[SW-1:0]};
			ST_OE_RD, ST_OE_CHK:
				rd_addr = {rr_idx, osl_q[SW-1:0]};
			ST_REC_SCAN, ST_REC_OUT:
				rd_addr = {rr_idx, sl_q[SW-1:0]};
			default:
				rd_addr = {tr_q, sl_q[SW-1:0]};
		endcase
		case (state_q)
			ST_RELAX:  pc_idx = d_q;
			ST_SETTLE: pc_idx = w_q;
			default:   pc_idx = rr_idx;
		endcase
		case (state_q)
			ST_HELLO_OUT, ST_REC_OUT, ST_ROUTE:
				emit = out_free;
			ST_FLOOD_CHK:
				emit = out_free && flood_ok;
			default:
				emit = 1'b0;
		endcase
	end

	assign cnt_rd  = cnt_q[cnt_idx];
	assign pc_rd   = pc_q[pc_idx];
	assign fh_rd   = fh_q[pc_idx];
	assign mem_we  = (state_q == ST_APPEND);
	assign wr_addr = {tr_q, cnt_rd[SW-1:0]};
	assign key     = reach_q[rr_idx] ? {1'b0, pc_rd} : COST_INF;
	assign sum_w   = {1'b0, wcost_q} + {4'b0, e_cost_q};
	assign sum_sat = (sum_w > {1'b0, COST_MAX}) ? COST_MAX : sum_w[PCOST_W-1:0];

	always_comb begin
		later_nz = 1'b0;
		nb_hit   = 1'b0;
		for (int i = 0; i < ROUTERS; i++) begin
			if (RCW'(i) > rr_q && cnt_q[i] != '0)
				later_nz = 1'b1;
			if (nbv_q[i] && nbl_q[i] == rd_link)
				nb_hit = 1'b1;
		end
	end
	assign rec_last = (sl_inc == cnt_rd) && !later_nz;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {link_q, cost_q};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			own_q     <= 4'd1;
			ov_q      <= 1'b0;
			settled_q <= '0;
			reach_q   <= '0;
			cmd_q     <= CMD_ADD_LINK;
			rn_q      <= '0;
			link_q    <= '0;
			cost_q    <= '0;
			arr_q     <= '0;
			tr_q      <= '0;
			sl_q      <= '0;
			osl_q     <= '0;
			rr_q      <= '0;
			iter_q    <= '0;
			w_q       <= '0;
			wfound_q  <= 1'b0;
			best_q    <= COST_INF;
			wcost_q   <= '0;
			whop_q    <= '0;
			e_link_q  <= '0;
			e_cost_q  <= '0;
			d_q       <= '0;
			o_kind_q  <= KIND_HELLO;
			o_subj_q  <= '0;
			o_rlink_q <= '0;
			o_cost_q  <= '0;
			o_slink_q <= '0;
			o_hop_q   <= '0;
			o_reach_q <= 1'b0;
			o_last_q  <= 1'b0;
			for (int i = 0; i < ROUTERS; i++) begin
				cnt_q[i] <= '0;
				nbv_q[i] <= 1'b0;
				nbl_q[i] <= '0;
				pc_q[i]  <= '0;
				fh_q[i]  <= '0;
			end
		end else begin
			if (cfg_we)
				own_q <= cfg_wdata;
			if (emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd;
						rn_q   <= router_num;
						link_q <= link_num;
						cost_q <= item_cost;
						arr_q  <= arrival_link;
						sl_q   <= '0;
						rr_q   <= '0;
						case (cmd)
							CMD_ADD_LINK: begin
								tr_q    <= own_idx;
								state_q <= own_ok ? ST_DUP_RD : ST_HELLO_OUT;
							end
							CMD_HELLO: begin
								if (rn_in_ok) begin
									nbv_q[rn_in_idx] <= 1'b1;
									nbl_q[rn_in_idx] <= link_num;
								end
								state_q <= ST_REC_SCAN;
							end
							CMD_RECORD: begin
								tr_q    <= rn_in_idx;
								state_q <= rn_in_ok ? ST_DUP_RD : ST_IDLE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DUP_RD: begin
					if (sl_q == cnt_rd) begin
						if (cnt_rd == CW'(LINKS_PER_ROUTER))
							state_q <= (cmd_q == CMD_ADD_LINK) ? ST_HELLO_OUT : ST_IDLE;
						else
							state_q <= ST_APPEND;
					end else begin
						state_q <= ST_DUP_CHK;
					end
				end
				ST_DUP_CHK: begin
					if (rd_data_q == {link_q, cost_q}) begin
						state_q <= (cmd_q == CMD_ADD_LINK) ? ST_HELLO_OUT : ST_IDLE;
					end else begin
						sl_q    <= sl_inc;
						state_q <= ST_DUP_RD;
					end
				end
				ST_APPEND: begin
					cnt_q[tr_q] <= cnt_rd + CW'(1);
					sl_q        <= '0;
					if (cmd_q == CMD_ADD_LINK) begin
						state_q <= ST_HELLO_OUT;
					end else begin
						tr_q <= own_idx;
						for (int i = 0; i < ROUTERS; i++) begin
							pc_q[i] <= '0;
							fh_q[i] <= '0;
						end
						if (own_ok) begin
							settled_q <= ROUTERS'(1) << own_idx;
							reach_q   <= ROUTERS'(1) << own_idx;
							state_q   <= ST_INIT_RD;
						end else begin
							settled_q <= '0;
							reach_q   <= '0;
							iter_q    <= RCW'(1);
							rr_q      <= '0;
							wfound_q  <= 1'b0;
							best_q    <= COST_INF;
							state_q   <= ST_SEL;
						end
					end
				end
				ST_HELLO_OUT: begin
					if (out_free) begin
						o_kind_q  <= KIND_HELLO;
						o_subj_q  <= own_q;
						o_rlink_q <= link_q;
						o_cost_q  <= '0;
						o_slink_q <= link_q;
						o_hop_q   <= '0;
						o_reach_q <= 1'b0;
						o_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_REC_SCAN: begin
					if (rr_end) begin
						state_q <= ST_IDLE;
					end else if (sl_q == cnt_rd) begin
						rr_q <= rr_q + RCW'(1);
						sl_q <= '0;
					end else begin
						state_q <= ST_REC_OUT;
					end
				end
				ST_REC_OUT: begin
					if (out_free) begin
						o_kind_q  <= KIND_RECORD;
						o_subj_q  <= 4'(rr_idx) + 4'd1;
						o_rlink_q <= rd_link;
						o_cost_q  <= {3'b0, rd_cost};
						o_slink_q <= link_q;
						o_hop_q   <= '0;
						o_reach_q <= 1'b0;
						o_last_q  <= rec_last;
						sl_q      <= sl_inc;
						state_q   <= ST_REC_SCAN;
					end
				end
				ST_INIT_RD: begin
					if (sl_q == cnt_rd) begin
						iter_q   <= RCW'(1);
						rr_q     <= '0;
						wfound_q <= 1'b0;
						best_q   <= COST_INF;
						state_q  <= ST_SEL;
					end else begin
						state_q <= ST_INIT_CHK;
					end
				end
				ST_INIT_CHK: begin
					for (int i = 0; i < ROUTERS; i++) begin
						if (RW'(i) != own_idx && nbv_q[i] && nbl_q[i] == rd_link) begin
							pc_q[i]    <= {3'b0, rd_cost};
							fh_q[i]    <= 4'(i + 1);
							reach_q[i] <= 1'b1;
						end
					end
					sl_q    <= sl_inc;
					state_q <= ST_INIT_RD;
				end
				ST_SEL: begin
					if (rr_end) begin
						if (wfound_q) begin
							state_q <= ST_SETTLE;
						end else begin
							sl_q    <= '0;
							rr_q    <= '0;
							state_q <= own_ok ? ST_FLOOD_RD : ST_ROUTE;
						end
					end else begin
						if (cnt_rd != '0 && !settled_q[rr_idx] && key <= best_q) begin
							best_q   <= key;
							w_q      <= rr_idx;
							wfound_q <= 1'b1;
						end
						rr_q <= rr_q + RCW'(1);
					end
				end
				ST_SETTLE: begin
					settled_q[w_q] <= 1'b1;
					wcost_q        <= pc_rd;
					whop_q         <= fh_rd;
					sl_q           <= '0;
					if (reach_q[w_q]) begin
						state_q <= ST_EDGE_RD;
					end else if (iter_q == RCW'(ROUTERS - 1)) begin
						rr_q    <= '0;
						state_q <= own_ok ? ST_FLOOD_RD : ST_ROUTE;
					end else begin
						iter_q   <= iter_q + RCW'(1);
						rr_q     <= '0;
						wfound_q <= 1'b0;
						best_q   <= COST_INF;
						state_q  <= ST_SEL;
					end
				end
				ST_EDGE_RD: begin
					if (sl_q != cnt_rd) begin
						state_q <= ST_EDGE_CAP;
					end else if (iter_q == RCW'(ROUTERS - 1)) begin
						sl_q    <= '0;
						rr_q    <= '0;
						state_q <= own_ok ? ST_FLOOD_RD : ST_ROUTE;
					end else begin
						iter_q   <= iter_q + RCW'(1);
						rr_q     <= '0;
						wfound_q <= 1'b0;
						best_q   <= COST_INF;
						state_q  <= ST_SEL;
					end
				end
				ST_EDGE_CAP: begin
					e_link_q <= rd_link;
					e_cost_q <= rd_cost;
					rr_q     <= '0;
					osl_q    <= '0;
					state_q  <= ST_OE_RD;
				end
				ST_OE_RD: begin
					if (rr_end) begin
						sl_q    <= sl_inc;
						state_q <= ST_EDGE_RD;
					end else if (rr_idx == w_q || osl_q == cnt_rd) begin
						rr_q  <= rr_q + RCW'(1);
						osl_q <= '0;
					end else begin
						state_q <= ST_OE_CHK;
					end
				end
				ST_OE_CHK: begin
					if (rd_link == e_link_q) begin
						d_q     <= rr_idx;
						state_q <= ST_RELAX;
					end else begin
						osl_q   <= osl_q + CW'(1);
						state_q <= ST_OE_RD;
					end
				end
				ST_RELAX: begin
					if (!settled_q[d_q] && (!reach_q[d_q] || sum_sat < pc_rd)) begin
						pc_q[d_q]    <= sum_sat;
						fh_q[d_q]    <= whop_q;
						reach_q[d_q] <= 1'b1;
					end
					sl_q    <= sl_inc;
					state_q <= ST_EDGE_RD;
				end
				ST_FLOOD_RD: begin
					if (sl_q == cnt_rd) begin
						rr_q    <= '0;
						state_q <= ST_ROUTE;
					end else begin
						state_q <= ST_FLOOD_CHK;
					end
				end
				ST_FLOOD_CHK: begin
					if (!flood_ok) begin
						sl_q    <= sl_inc;
						state_q <= ST_FLOOD_RD;
					end else if (out_free) begin
						o_kind_q  <= KIND_RECORD;
						o_subj_q  <= rn_q;
						o_rlink_q <= link_q;
						o_cost_q  <= {3'b0, cost_q};
						o_slink_q <= rd_link;
						o_hop_q   <= '0;
						o_reach_q <= 1'b0;
						o_last_q  <= 1'b0;
						sl_q      <= sl_inc;
						state_q   <= ST_FLOOD_RD;
					end
				end
				ST_ROUTE: begin
					if (out_free) begin
						o_kind_q  <= KIND_ROUTE;
						o_subj_q  <= 4'(rr_idx) + 4'd1;
						o_rlink_q <= '0;
						o_cost_q  <= reach_q[rr_idx] ? pc_rd : '0;
						o_slink_q <= '0;
						o_hop_q   <= reach_q[rr_idx] ? fh_rd : '0;
						o_reach_q <= reach_q[rr_idx];
						o_last_q  <= (rr_q == RCW'(ROUTERS - 1));
						rr_q      <= rr_q + RCW'(1);
						if (rr_q == RCW'(ROUTERS - 1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = ov_q;
	assign kind           = o_kind_q;
	assign subject_router = o_subj_q;
	assign rec_link       = o_rlink_q;
	assign cost_value     = o_cost_q;
	assign send_link      = o_slink_q;
	assign next_hop       = o_hop_q;
	assign reachable      = o_reach_q;
	assign last           = o_last_q;

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPEND |-> cnt_rd < CW'(LINKS_PER_ROUTER))
		else $error("append into full row");

	a_relax_other: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX |-> d_q != w_q)
		else $error("relaxing node onto itself");

	a_side_fields: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_kind_q != KIND_ROUTE |-> !o_reach_q && o_hop_q == '0)
		else $error("route fields set on hello or record");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_kind_q == KIND_ROUTE && !o_reach_q |-> o_cost_q == '0 && o_hop_q == '0)
		else $error("unreachable route carries cost or hop");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for link_state_route_engine_top: a route predictor
// and result scoreboard class, item channel tasks and a random out_ready driver.
// Depends on lsre_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
	import lsre_pkg::*;

	localparam int NR = 8;
	localparam int NL = 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  subj;
		logic [7:0]  rlink;
		logic [18:0] cost;
		logic [7:0]  slink;
		logic [3:0]  hop;
		logic        reach;
		logic        last;
	} res_t;

	class route_scoreboard;
		int unsigned own_id;
		logic [7:0]  tlink [NR][NL];
		logic [15:0] tcost [NR][NL];
		int unsigned cnt [NR];
		logic [8:0]  nbr [NR];
		int unsigned pc [NR];
		int unsigned fh [NR];
		logic [7:0]  settled, reach;
		res_t        pending [$];
		int          errors;
		int          checked;

		function new();
			own_id = 1;
			errors = 0;
			checked = 0;
			foreach (cnt[i]) begin
				cnt[i] = 0;
				nbr[i] = '0;
			end
		endfunction

		function bit ok_id(int unsigned r);
			return r >= 1 && r <= NR;
		endfunction

		function bit store(int unsigned r, logic [7:0] l, logic [15:0] c);
			if (!ok_id(r))
				return 0;
			for (int s = 0; s < cnt[r-1]; s++)
				if (tlink[r-1][s] == l && tcost[r-1][s] == c)
					return 0;
			if (cnt[r-1] >= NL)
				return 0;
			tlink[r-1][cnt[r-1]] = l;
			tcost[r-1][cnt[r-1]] = c;
			cnt[r-1]++;
			return 1;
		endfunction

		function int unsigned far_end(int unsigned w, logic [7:0] l);
			for (int i = 1; i <= NR; i++) begin
				if (i == w)
					continue;
				for (int s = 0; s < cnt[i-1]; s++)
					if (tlink[i-1][s] == l)
						return i;
			end
			return 0;
		endfunction

		function void shortest_paths();
			int unsigned w, key, best, d, sum;
			settled = 0;
			reach = 0;
			foreach (pc[i]) begin
				pc[i] = 0;
				fh[i] = 0;
			end
			if (ok_id(own_id)) begin
				settled[own_id-1] = 1;
				reach = settled;
				for (int i = 1; i <= NR; i++) begin
					if (i == own_id || !nbr[i-1][8])
						continue;
					for (int s = 0; s < cnt[own_id-1]; s++)
						if (tlink[own_id-1][s] == nbr[i-1][7:0]) begin
							pc[i-1] = tcost[own_id-1][s];
							fh[i-1] = i;
							reach[i-1] = 1;
						end
				end
			end
			for (int n = 1; n < NR; n++) begin
				w = 0;
				best = 32'h80000;
				for (int i = 1; i <= NR; i++) begin
					if (cnt[i-1] == 0 || settled[i-1])
						continue;
					key = reach[i-1] ? pc[i-1] : 32'h80000;
					if (key <= best) begin
						best = key;
						w = i;
					end
				end
				if (w == 0)
					break;
				settled[w-1] = 1;
				if (!reach[w-1])
					continue;
				for (int s = 0; s < cnt[w-1]; s++) begin
					d = far_end(w, tlink[w-1][s]);
					if (d == 0 || settled[d-1])
						continue;
					sum = pc[w-1] + tcost[w-1][s];
					if (sum > COST_MAX)
						sum = COST_MAX;
					if (!reach[d-1] || sum < pc[d-1]) begin
						pc[d-1] = sum;
						fh[d-1] = fh[w-1];
						reach[d-1] = 1;
					end
				end
			end
		endfunction

		function void push(logic [1:0] k, int unsigned sj, logic [7:0] rl,
				int unsigned c, logic [7:0] sl, int unsigned h, bit rc);
			res_t r;
			r.kind = k;
			r.subj = sj[3:0];
			r.rlink = rl;
			r.cost = c[18:0];
			r.slink = sl;
			r.hop = h[3:0];
			r.reach = rc;
			r.last = 0;
			pending.push_back(r);
		endfunction

		// returns number of results the item causes
		function int note_item(logic [1:0] c, logic [3:0] rn, logic [7:0] l,
				logic [15:0] lc, logic [7:0] arr);
			int base;
			base = pending.size();
			if (c == CMD_ADD_LINK) begin
				void'(store(own_id, l, lc));
				push(KIND_HELLO, own_id, l, 0, l, 0, 0);
			end else if (c == CMD_HELLO) begin
				if (ok_id(rn))
					nbr[rn-1] = {1'b1, l};
				for (int r = 1; r <= NR; r++)
					for (int s = 0; s < cnt[r-1]; s++)
						push(KIND_RECORD, r, tlink[r-1][s], tcost[r-1][s], l, 0, 0);
			end else if (c == CMD_RECORD) begin
				if (!store(rn, l, lc))
					return 0;
				shortest_paths();
				if (ok_id(own_id))
					for (int s = 0; s < cnt[own_id-1]; s++) begin
						if (tlink[own_id-1][s] == arr)
							continue;
						for (int j = 0; j < NR; j++)
							if (nbr[j][8] && nbr[j][7:0] == tlink[own_id-1][s]) begin
								push(KIND_RECORD, rn, l, lc, tlink[own_id-1][s], 0, 0);
								break;
							end
					end
				for (int r = 1; r <= NR; r++)
					push(KIND_ROUTE, r, 0, reach[r-1] ? pc[r-1] : 0, 0,
						reach[r-1] ? fh[r-1] : 0, reach[r-1]);
			end
			if (pending.size() > base)
				pending[pending.size()-1].last = 1;
			return pending.size() - base;
		endfunction

		function void check_result(res_t got);
			res_t exp;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				$display("%0t: mismatch expected %p actual %p", $time, exp, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0, arst_n = 0;
	logic        cfg_we = 0;
	logic [3:0]  cfg_wdata = 0;
	logic        in_valid = 0, in_ready;
	logic [1:0]  cmd = 0;
	logic [3:0]  router_num = 0;
	logic [7:0]  link_num = 0, arrival_link = 0;
	logic [15:0] item_cost = 0;
	logic        out_valid, out_ready = 0;
	logic [1:0]  kind;
	logic [3:0]  subject_router, next_hop;
	logic [7:0]  rec_link, send_link;
	logic [18:0] cost_value;
	logic        reachable, last;

	route_scoreboard sb = new();
	int send_idle = 0, recv_idle = 0;
	int items = 0, results = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	link_state_route_engine_top #(.ROUTERS(NR), .LINKS_PER_ROUTER(NL)) uut (.*);

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result({kind, subject_router, rec_link, cost_value,
					send_link, next_hop, reachable, last});
				results++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// in_valid stays high into the next item when the sender does not idle
	task automatic send_item(logic [1:0] c, logic [3:0] rn, logic [7:0] l,
			logic [15:0] lc, logic [7:0] arr);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		cmd <= c;
		router_num <= rn;
		link_num <= l;
		item_cost <= lc;
		arrival_link <= arr;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		void'(sb.note_item(c, rn, l, lc, arr));
		items++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_own(logic [3:0] id);
		drain();
		cfg_we <= 1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 0;
		sb.own_id = id;
	endtask

	task automatic rand_item();
		int p;
		logic [3:0] rn;
		logic [7:0] l;
		p = $urandom_range(99);
		rn = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NR, 1));
		l = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
		if (p < 15)
			send_item(CMD_ADD_LINK, rn, l, 16'($urandom), 8'($urandom_range(7)));
		else if (p < 35)
			send_item(CMD_HELLO, rn, l, 16'($urandom), 8'($urandom));
		else if (p < 97)
			send_item(CMD_RECORD, rn, l,
				($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
				8'($urandom_range(8)));
		else
			send_item(CMD_NOP, rn, l, 16'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: own links, hellos, records, dup, range and extremes
		send_item(CMD_ADD_LINK, 0, 8'd1, 16'd5, 0);
		send_item(CMD_ADD_LINK, 0, 8'd255, 16'hFFFF, 0);
		send_item(CMD_ADD_LINK, 0, 8'd1, 16'd5, 0);
		send_item(CMD_HELLO, 4'd2, 8'd1, 0, 0);
		send_item(CMD_HELLO, 4'd3, 8'd255, 0, 0);
		send_item(CMD_HELLO, 4'd1, 8'd0, 0, 0);
		send_item(CMD_RECORD, 4'd2, 8'd1, 16'd5, 8'd1);
		send_item(CMD_RECORD, 4'd2, 8'd1, 16'd5, 8'd1);
		send_item(CMD_RECORD, 4'd3, 8'd255, 16'hFFFF, 8'd0);
		send_item(CMD_RECORD, 4'd3, 8'd7, 16'hFFFF, 8'd255);
		send_item(CMD_RECORD, 4'd8, 8'd7, 16'hFFFF, 8'd0);
		send_item(CMD_RECORD, 4'd2, 8'd7, 16'd3, 8'd0);
		send_item(CMD_RECORD, 4'd0, 8'd9, 16'd1, 8'd0);
		send_item(CMD_RECORD, 4'd15, 8'd9, 16'd1, 8'd0);
		send_item(CMD_HELLO, 4'd0, 8'd200, 0, 0);
		send_item(CMD_HELLO, 4'd15, 8'd170, 0, 0);
		send_item(CMD_NOP, 4'd5, 8'd85, 16'hAAAA, 8'd170);
		for (int i = 0; i < 9; i++)
			send_item(CMD_RECORD, 4'd4, 8'(i), 16'h5555, 8'd0);
		set_own(4'd8);
		send_item(CMD_ADD_LINK, 0, 8'd7, 16'd2, 0);
		send_item(CMD_RECORD, 4'd5, 8'd9, 16'd4, 8'd0);
		set_own(4'd0);
		send_item(CMD_ADD_LINK, 0, 8'd3, 16'd1, 0);
		send_item(CMD_RECORD, 4'd6, 8'd3, 16'd4, 8'd0);
		set_own(4'd15);
		send_item(CMD_RECORD, 4'd6, 8'd4, 16'd4, 8'd0);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 32 : (ph == 1) ? 55 : 0;
			recv_idle = (ph == 0) ? 55 : (ph == 1) ? 32 : 0;
			set_own(4'($urandom_range(NR, 1)));
			for (int i = 0; i < 130; i++)
				rand_item();
		end
		set_own(4'd1);
		drain();
		$display("%0d items sent, %0d results checked, own id settings incl. 0, 1, 8, 15",
			items, sb.checked);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb_top failed");
		$finish;
	end
endmodule
